// ----- rtl/bbl_pkg.sv -----
`timescale 1ns / 1ps

package bbl_pkg;

    // Fixed field widths
    localparam int SAMPLE_WIDTH        = 16;
    localparam int GAIN_W              = 31;
    localparam int COEF_W              = 32;
    localparam int DEF_COEF_FRAC_BITS  = 30;

    // Feed-forward product: 32-bit signed gain times (SAMPLE_WIDTH+2)-bit input sum
    localparam int FF_W                = COEF_W + SAMPLE_WIDTH + 2;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH         = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W           = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B0      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TWO = 2'd2;

    // Request command codes
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                           cmd;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } req_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic                           saturated;
    } rsp_item_t;

    typedef struct packed {
        logic                    clear;
        logic signed [FF_W-1:0]  ff;
    } queue_entry_t;

endpackage

// ----- rtl/bbl_front.sv -----
`timescale 1ns / 1ps

module bbl_front
    import bbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_item_t          req_data,
    input  logic [GAIN_W-1:0]  gain_b0,
    input  logic               queue_full,
    output logic               push,
    output queue_entry_t       entry
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int S_W = SAMPLE_WIDTH + 2;

    logic signed [W-1:0]      x1_reg;
    logic signed [W-1:0]      x1_next;
    logic signed [W-1:0]      x2_reg;
    logic signed [W-1:0]      x2_next;
    logic signed [S_W-1:0]    in_sum;
    logic signed [COEF_W-1:0] gain_s;
    logic signed [FF_W-1:0]   ff_prod;
    logic                     is_clear;

    // Accept while the queue has room
    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full;
    assign is_clear  = (req_data.cmd == CMD_CLEAR);

    // Form x0 + 2*x1 + x2 and scale it by the feed-forward gain
    always_comb
    begin
        in_sum      = S_W'(req_data.sample) + (S_W'(x1_reg) <<< 1) + S_W'(x2_reg);
        gain_s      = {1'b0, gain_b0};
        ff_prod     = gain_s * in_sum;
        entry.clear = is_clear;
        entry.ff    = is_clear ? '0 : ff_prod;
    end

    // Advance the input history, drop it on clear
    always_comb
    begin
        x1_next = x1_reg;
        x2_next = x2_reg;
        if (push)
        begin
            if (is_clear)
            begin
                x1_next = '0;
                x2_next = '0;
            end
            else
            begin
                x1_next = req_data.sample;
                x2_next = x1_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
        end
        else
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
    end

endmodule

// ----- rtl/bbl_queue.sv -----
`timescale 1ns / 1ps

module bbl_queue
    import bbl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  queue_entry_t wr_entry,
    output logic         full,
    input  logic         pop,
    output logic         rd_valid,
    output queue_entry_t rd_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t       slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slots_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries until popped
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ----- rtl/bbl_back.sv -----
`timescale 1ns / 1ps

module bbl_back
    import bbl_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     entry_valid,
    input  queue_entry_t             entry,
    output logic                     pop,
    input  logic signed [COEF_W-1:0] feedback_one,
    input  logic signed [COEF_W-1:0] feedback_two,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output rsp_item_t                rsp_data
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int ACC_W  = FF_W + 1;
    localparam int PROD_W = COEF_W + SAMPLE_WIDTH;
    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

    logic signed [W-1:0]      y1_reg;
    logic signed [W-1:0]      y1_next;
    logic signed [W-1:0]      y2_reg;
    logic signed [W-1:0]      y2_next;
    logic signed [PROD_W-1:0] p2_reg;
    logic signed [PROD_W-1:0] p2_next;
    logic signed [PROD_W-1:0] prod1;
    logic signed [W-1:0]      fb_sel;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  yq;
    logic                     in_range;
    logic signed [W-1:0]      y_sat;
    logic                     sat;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    rsp_item_t                out_data_reg;
    rsp_item_t                out_data_next;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // Take the next entry when the output register is free or being emptied
    assign pop = entry_valid && (!out_valid_reg || !rsp_stall);

    // Sum, round to nearest and saturate; only f1*y1 sits in the feedback loop
    always_comb
    begin
        prod1    = feedback_one * y1_reg;
        acc      = ACC_W'(entry.ff) - ACC_W'(prod1) - ACC_W'(p2_reg);
        rnd      = acc + RND_HALF;
        yq       = rnd >>> COEF_FRAC_BITS;
        in_range = (&yq[ACC_W-1:W-1]) || !(|yq[ACC_W-1:W-1]);
        if (in_range)
        begin
            y_sat = yq[W-1:0];
            sat   = 1'b0;
        end
        else
        begin
            y_sat = yq[ACC_W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            sat   = 1'b1;
        end
    end

    // Advance output history and result register
    always_comb
    begin
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        fb_sel         = y2_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            if (entry.clear)
            begin
                y1_next       = '0;
                y2_next       = '0;
                fb_sel        = '0;
                out_data_next = '0;
            end
            else
            begin
                y1_next                 = y_sat;
                y2_next                 = y1_reg;
                fb_sel                  = y1_reg;
                out_data_next.filtered  = y_sat;
                out_data_next.saturated = sat;
            end
        end
        // Precompute f2*y2 for the following sample
        p2_next = feedback_two * fb_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg        <= '0;
            y2_reg        <= '0;
            p2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            y1_reg        <= y1_next;
            y2_reg        <= y2_next;
            p2_reg        <= p2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/butterworth_biquad_lowpass_core.sv -----
`timescale 1ns / 1ps

// Second-order low-pass biquad, y = b0*(x0+2x1+x2) - f1*y1 - f2*y2, Q2.F coefficients.
// Request channel (req_valid/req_stall/req_data): cmd selects filter or clear; a
// request is taken at an edge with req_valid high and req_stall low.
// Response channel (rsp_valid/rsp_stall/rsp_data): one response per request, in
// order, with the rounded, saturated sample and a clip flag; zero after a clear.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 gain_b0,
// 1 feedback_one, 2 feedback_two; cfg_ready is always high. Write only while idle.
// A request taken at an edge is written into the queue and popped into the response
// register once it is free or being emptied; the response is presented from then on.
// Throughput: one request per cycle unless the receiver stalls; the loop through the
// f1*y1 multiply and the round/saturate stage closes through the y1 register, while
// b0*sum is formed at the front and f2*y2 is precomputed into a register ahead.
// Reset clears the histories, the coefficients and the two-entry queue.
// When the receiver stalls the response register holds, up to two requests queue
// behind it, and then req_stall rises.
module butterworth_biquad_lowpass_core
    import bbl_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_item_t            req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_item_t            rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    logic [GAIN_W-1:0]        gain_b0_reg;
    logic signed [COEF_W-1:0] feedback_one_reg;
    logic signed [COEF_W-1:0] feedback_two_reg;
    logic                     queue_full;
    logic                     push;
    queue_entry_t             wr_entry;
    logic                     pop;
    logic                     rd_valid;
    queue_entry_t             rd_entry;

    assign cfg_ready = 1'b1;

    // Hold the coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_b0_reg      <= '0;
            feedback_one_reg <= '0;
            feedback_two_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAIN_B0:      gain_b0_reg      <= cfg_data[GAIN_W-1:0];
                CFG_FEEDBACK_ONE: feedback_one_reg <= cfg_data;
                CFG_FEEDBACK_TWO: feedback_two_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    bbl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .gain_b0    (gain_b0_reg),
        .queue_full (queue_full),
        .push       (push),
        .entry      (wr_entry)
    );

    bbl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (queue_full),
        .pop      (pop),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry)
    );

    bbl_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (rd_valid),
        .entry        (rd_entry),
        .pop          (pop),
        .feedback_one (feedback_one_reg),
        .feedback_two (feedback_two_reg),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp_data     (rsp_data)
    );

endmodule
